/* rtl/drre_pkg.sv */
// drre_pkg: shared types, constants and helpers of the decade resistance relay encoder
`default_nettype none

package drre_pkg;

  // decade count and derived widths
  localparam int unsigned NumDecades = 6;
  localparam int unsigned WordW      = 48;
  localparam int unsigned OhmsW      = 20;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned BcdW       = 24;
  localparam int unsigned BitIdxW    = $clog2(WordW);

  // resistance limit: the smaller of the cap and the largest value the decades can show
  localparam logic [OhmsW-1:0]  OhmsCap   = 20'd999999;
  localparam longint unsigned   DecPow    = longint'(10) ** NumDecades;
  localparam int unsigned       SumW      = $clog2(DecPow);
  localparam logic [OhmsW-1:0]  OhmsLimit = (DecPow - 64'd1 > 64'(OhmsCap)) ?
                                            OhmsCap : OhmsW'(DecPow - 64'd1);

  // output relay positions in byte 0
  localparam int unsigned ConnectBit = 6;
  localparam int unsigned ShortBit   = 7;

  // command codes
  typedef enum logic [2:0] {
    KIND_SET_RES    = 3'd0,
    KIND_SET_DECADE = 3'd1,
    KIND_SET_BIT    = 3'd2,
    KIND_SET_OUTPUT = 3'd3,
    KIND_LOAD_RAW   = 3'd4,
    KIND_SET_ENABLE = 3'd5
  } drre_kind_e;

  typedef logic [NumDecades-1:0][DigitW-1:0] drre_digits_t;

  // command beat
  typedef struct packed {
    logic [2:0]        kind;
    logic [OhmsW-1:0]  ohms_value;
    logic [3:0]        decade_number;
    logic [DigitW-1:0] digit_value;
    logic [2:0]        bit_index;
    logic              flag_value;
    logic [WordW-1:0]  raw_word;
  } drre_in_t;

  // result beat
  typedef struct packed {
    logic [WordW-1:0] relay_word;
    logic [OhmsW-1:0] resistance_ohms;
    logic             resistance_known;
    logic [BcdW-1:0]  digits_bcd;
    logic             connect_state;
    logic             driver_enabled;
    logic             status;
  } drre_out_t;

  // digit to six-relay tap pattern
  function automatic logic [7:0] tap_pattern(input logic [DigitW-1:0] digit);
    logic [7:0] taps;
    unique case (digit)
      4'd0:    taps = 8'b0000_0001;
      4'd1:    taps = 8'b0000_0100;
      4'd2:    taps = 8'b0000_1010;
      4'd3:    taps = 8'b0000_1000;
      4'd4:    taps = 8'b0001_0010;
      4'd5:    taps = 8'b0001_0000;
      4'd6:    taps = 8'b0010_0010;
      4'd7:    taps = 8'b0010_0000;
      4'd8:    taps = 8'b0000_0010;
      default: taps = 8'b0000_0000;
    endcase
    return taps;
  endfunction

  // decade tap bytes, output relays left open
  function automatic logic [WordW-1:0] word_from_digits(input drre_digits_t digits);
    logic [WordW-1:0] word;
    word = '0;
    for (int k = 0; k < NumDecades; k++) begin
      if (k < WordW / 8) begin
        word[8*k +: 8] = tap_pattern(digits[k]);
      end
    end
    return word;
  endfunction

  // connect on, short off
  function automatic logic [WordW-1:0] with_connect(input logic [WordW-1:0] word);
    logic [WordW-1:0] res;
    res = word;
    res[ConnectBit] = 1'b1;
    res[ShortBit]   = 1'b0;
    return res;
  endfunction

  // short on, connect off
  function automatic logic [WordW-1:0] with_short(input logic [WordW-1:0] word);
    logic [WordW-1:0] res;
    res = word;
    res[ConnectBit] = 1'b0;
    res[ShortBit]   = 1'b1;
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/decade_resistance_relay_encoder.sv */
// decade_resistance_relay_encoder: command decoder and relay word state of the resistance box
// A result beat is offered from the state registers. Throughput: one command beat per clock
// unless the result stalls, set by the single pass from the command register through the
// digit split (parallel constant reciprocal multiplies) into the state.
// A stalled result holds the state; the command register still takes one beat meanwhile.
// Reset (asynchronous, active low): all relays open, digits and resistance zero,
// resistance known, output disconnected, driver disabled, no beats held.
`default_nettype none

module decade_resistance_relay_encoder import drre_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire drre_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output drre_out_t     out_data_o
);

  // handshake and command register
  logic     in_valid_q;
  drre_in_t in_q;
  logic     out_valid_q;
  logic     advance;
  logic     fire;

  // relay box state
  logic [WordW-1:0] relay_q, relay_d;
  drre_digits_t     digits_q, digits_d;
  logic [OhmsW-1:0] ohms_q, ohms_d;
  logic             known_q, known_d;
  logic             connected_q, connected_d;
  logic             enable_q, enable_d;
  logic             status_q, status_d;

  // datapath
  logic [OhmsW-1:0]   ohms_sat;
  logic [OhmsW-1:0]   quot [NumDecades+1];
  drre_digits_t       conv_digits;
  drre_digits_t       set_digits;
  logic [SumW-1:0]    digit_sum;
  logic [SumW-1:0]    sum_sat;
  logic               dec_ok;
  logic [3:0]         dec_m1;
  logic [BitIdxW-1:0] bit_idx;
  logic               rebuild;
  logic               digits_ok;
  logic [BcdW-1:0]    bcd;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // command register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // command register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // requested resistance, saturated
  assign ohms_sat = (in_q.ohms_value > OhmsLimit) ? OhmsLimit : in_q.ohms_value;

  // quotients by powers of ten through exact reciprocal multiplies
  for (genvar k = 0; k <= NumDecades; k++) begin : g_quot
    localparam longint unsigned Div   = longint'(10) ** k;
    localparam int unsigned     Lg    = $clog2(Div);
    localparam int unsigned     Shift = OhmsW + Lg;
    localparam longint unsigned Mul   = ((64'd1 << Shift) + Div - 64'd1) / Div;
    logic [63:0] prod;
    assign prod    = 64'(ohms_sat) * Mul;
    assign quot[k] = OhmsW'(prod >> Shift);
  end

  // decimal digits of the saturated resistance
  for (genvar k = 0; k < NumDecades; k++) begin : g_digit
    logic [OhmsW-1:0] times_ten;
    logic [OhmsW-1:0] rem;
    assign times_ten      = (quot[k+1] << 3) + (quot[k+1] << 1);
    assign rem            = quot[k] - times_ten;
    assign conv_digits[k] = rem[DigitW-1:0];
  end

  // decade and bit argument checks
  assign dec_m1  = in_q.decade_number - 4'd1;
  assign dec_ok  = (in_q.decade_number >= 4'd1) && (in_q.decade_number <= 4'(NumDecades));
  assign bit_idx = BitIdxW'({dec_m1[2:0], in_q.bit_index});

  // digits with one decade replaced, and their value
  always_comb begin
    set_digits = digits_q;
    for (int k = 0; k < NumDecades; k++) begin
      if (4'(k + 1) == in_q.decade_number) begin
        set_digits[k] = in_q.digit_value;
      end
    end
    digit_sum = '0;
    for (int k = 0; k < NumDecades; k++) begin
      digit_sum = digit_sum + SumW'(longint'(10) ** k) * SumW'(set_digits[k]);
    end
    sum_sat = (digit_sum > SumW'(OhmsLimit)) ? SumW'(OhmsLimit) : digit_sum;
  end

  // next state
  always_comb begin
    relay_d     = relay_q;
    digits_d    = digits_q;
    ohms_d      = ohms_q;
    known_d     = known_q;
    connected_d = connected_q;
    enable_d    = enable_q;
    status_d    = 1'b0;
    rebuild     = 1'b0;
    unique case (drre_kind_e'(in_q.kind))
      KIND_SET_RES: begin
        digits_d = conv_digits;
        ohms_d   = ohms_sat;
        rebuild  = 1'b1;
      end
      KIND_SET_DECADE: begin
        if (!dec_ok || in_q.digit_value > 4'd9) begin
          status_d = 1'b1;
        end else begin
          digits_d = set_digits;
          ohms_d   = OhmsW'(sum_sat);
          rebuild  = 1'b1;
        end
      end
      KIND_SET_BIT: begin
        if (!dec_ok || in_q.bit_index > 3'd5) begin
          status_d = 1'b1;
        end else begin
          if (32'(bit_idx) < WordW) begin
            relay_d[bit_idx] = in_q.flag_value;
          end
          known_d = 1'b0;
        end
      end
      KIND_SET_OUTPUT: begin
        connected_d = in_q.flag_value;
        if (!in_q.flag_value) begin
          relay_d = with_short(relay_q);
        end else if (!known_q) begin
          relay_d = with_connect(relay_q);
        end else if (ohms_q == '0) begin
          relay_d = with_short(relay_q);
        end else begin
          relay_d = with_connect(word_from_digits(digits_q));
        end
      end
      KIND_LOAD_RAW: begin
        relay_d = in_q.raw_word;
      end
      KIND_SET_ENABLE: begin
        enable_d = in_q.flag_value;
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
    // rebuild the word after a resistance or digit change
    if (rebuild) begin
      relay_d     = (ohms_d == '0) ? with_short('0) : with_connect(word_from_digits(digits_d));
      known_d     = 1'b1;
      connected_d = 1'b1;
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      relay_q     <= '0;
      digits_q    <= '0;
      ohms_q      <= '0;
      known_q     <= 1'b1;
      connected_q <= 1'b0;
      enable_q    <= 1'b0;
      status_q    <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      relay_q     <= relay_d;
      digits_q    <= digits_d;
      ohms_q      <= ohms_d;
      known_q     <= known_d;
      connected_q <= connected_d;
      enable_q    <= enable_d;
      status_q    <= status_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // stored digits as bcd, missing decades zero
  always_comb begin
    bcd = '0;
    for (int k = 0; k < NumDecades; k++) begin
      if (k < BcdW / DigitW) begin
        bcd[DigitW*k +: DigitW] = digits_q[k];
      end
    end
  end

  // result beat
  assign out_valid_o                 = out_valid_q;
  assign out_data_o.relay_word       = relay_q;
  assign out_data_o.resistance_ohms  = ohms_q;
  assign out_data_o.resistance_known = known_q;
  assign out_data_o.digits_bcd       = bcd;
  assign out_data_o.connect_state    = connected_q;
  assign out_data_o.driver_enabled   = enable_q;
  assign out_data_o.status           = status_q;

  // every stored digit is decimal
  always_comb begin
    digits_ok = 1'b1;
    for (int k = 0; k < NumDecades; k++) begin
      if (digits_q[k] > 4'd9) begin
        digits_ok = 1'b0;
      end
    end
  end

  // checks
  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni) digits_ok)
    else $error("stored digit above nine");

  a_ohms_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ohms_q <= OhmsLimit)
    else $error("programmed resistance above limit");

  a_set_res_connects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.kind == KIND_SET_RES) |=> (known_q && connected_q && !status_q))
    else $error("set resistance left output unknown or disconnected");

  a_unknown_kind_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.kind > KIND_SET_ENABLE) |=> (status_q && $stable(relay_q)))
    else $error("unknown command changed the relays or was not flagged");

endmodule

`default_nettype wire
